FILE: hw/rtl/fpbr_pkg.sv
// ----------------------------------------------------------------------------
// fpbr_pkg
// shared types and constants of the flash page buffer ring
// ----------------------------------------------------------------------------
package fpbr_pkg;

   // default geometry
   localparam int DEF_NUM_BUFFERS  = 4;
   localparam int DEF_PAGE_BYTES   = 256;
   localparam int DEF_PACKET_BYTES = 32;

   // fixed field widths
   localparam int MODE_W       = 2;
   localparam int DATA_W       = 64;
   localparam int STATUS_W     = 4;
   localparam int PAGE_ADDR_W  = 21;
   localparam int FLASH_ADDR_W = 22;
   localparam int ORDER_W      = 16;
   localparam int CSR_IDX_W    = 1;

   // register reset values
   localparam logic [FLASH_ADDR_W-1:0] RING_START_RESET = 22'd1536;
   localparam logic [FLASH_ADDR_W-1:0] FLASH_SIZE_RESET = 22'h200000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RING_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_SIZE = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_BEAT    = 2'd0,
      MODE_SERVICE = 2'd1,
      MODE_FLUSH   = 2'd2,
      MODE_REINIT  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ACCEPTED   = 4'd0,
      STAT_REJECTED   = 4'd1,
      STAT_OVERFLOW   = 4'd2,
      STAT_IDLE       = 4'd3,
      STAT_BUSY_WAIT  = 4'd4,
      STAT_DONE       = 4'd5,
      STAT_STARTED    = 4'd6,
      STAT_FLASH_FULL = 4'd7,
      STAT_BUSY_SKIP  = 4'd8,
      STAT_FLUSHED    = 4'd9,
      STAT_NOTHING    = 4'd10,
      STAT_REINIT     = 4'd11,
      STAT_IGNORED    = 4'd12
   } status_type;

   typedef enum logic [1:0] {
      PH_EMPTY   = 2'd0,
      PH_FILLING = 2'd1,
      PH_READY   = 2'd2,
      PH_WRITING = 2'd3
   } phase_type;

endpackage

FILE: hw/rtl/fpbr_req_if.sv
// ----------------------------------------------------------------------------
// fpbr_req_if
// request channel: packet beats, service ticks, flush and reinit
// ----------------------------------------------------------------------------
interface fpbr_req_if
   import fpbr_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [DATA_W-1:0]   data_word;
   logic                flash_busy;

   modport source (output valid, mode, data_word, flash_busy, input ready);
   modport sink   (input valid, mode, data_word, flash_busy, output ready);
endinterface

FILE: hw/rtl/fpbr_rsp_if.sv
// ----------------------------------------------------------------------------
// fpbr_rsp_if
// response channel: status results and page program beats
// ----------------------------------------------------------------------------
interface fpbr_rsp_if
   import fpbr_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [STATUS_W-1:0]    status;
   logic [PAGE_ADDR_W-1:0] page_address;
   logic [DATA_W-1:0]      page_word;
   logic                   last;
   logic                   overflow;
   logic                   pending;

   modport source (output valid, kind, status, page_address, page_word, last, overflow,
                   pending, input ready);
   modport sink   (input valid, kind, status, page_address, page_word, last, overflow,
                   pending, output ready);
endinterface

FILE: hw/rtl/fpbr_ram.sv
// ----------------------------------------------------------------------------
// fpbr_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module fpbr_ram
   import fpbr_pkg::*;
#(
   parameter int   WIDTH = DATA_W,
   parameter int   DEPTH = DEF_NUM_BUFFERS * DEF_PAGE_BYTES / 8,
   localparam int  AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/flash_page_buffer_ring.sv
// ----------------------------------------------------------------------------
// flash_page_buffer_ring
// path: beat without page completion, flush, reinit, busy wait and write done with
//   a filling buffer: idle, finish, send; page completion, ticks with no write in
//   progress, write done with no filling buffer: scan first (one buffer per cycle)
// a started write streams PAGE_BYTES/8 beats through the ram read, load, send states
// one transaction at a time: req ready only while idle
// reset: synchronous, buffer 0 filling, registers to defaults; page store not cleared
// ----------------------------------------------------------------------------
module flash_page_buffer_ring
   import fpbr_pkg::*;
#(
   parameter int NUM_BUFFERS  = DEF_NUM_BUFFERS,
   parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
   parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
   input  logic                    clock,
   input  logic                    reset,
   fpbr_req_if.sink                req_ch,
   fpbr_rsp_if.source              rsp_ch,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [FLASH_ADDR_W-1:0] csr_wdata
);

   // geometry
   localparam int WORDS_PER_PAGE   = PAGE_BYTES / 8;
   localparam int BEATS_PER_PACKET = PACKET_BYTES / 8;
   localparam int PACKETS_PER_PAGE = PAGE_BYTES / PACKET_BYTES;
   localparam int STORE_WORDS      = NUM_BUFFERS * WORDS_PER_PAGE;
   localparam int BUF_W            = $clog2(NUM_BUFFERS);
   localparam int ADDR_W           = $clog2(STORE_WORDS);
   localparam int WORD_W           = $clog2(WORDS_PER_PAGE);
   localparam int LVL_W            = WORD_W + 1;
   localparam int BEAT_W           = (BEATS_PER_PACKET > 1) ? $clog2(BEATS_PER_PACKET) : 1;
   localparam int CNT_W            = $clog2(PACKETS_PER_PAGE + 1);
   localparam int SUM_W            = FLASH_ADDR_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN,
      ST_SEND,
      ST_RD,
      ST_LOAD
   } state_type;

   // sequencer and transaction context
   state_type               state_ff, state_in;
   mode_type                mode_ff, mode_in;
   logic                    busy_ff, busy_in;
   logic                    full_ff, full_in;
   status_type              status_ff, status_in;

   // per-buffer bookkeeping
   phase_type               phase_ff [NUM_BUFFERS];
   phase_type               phase_in [NUM_BUFFERS];
   logic [CNT_W-1:0]        fill_ff  [NUM_BUFFERS];
   logic [CNT_W-1:0]        fill_in  [NUM_BUFFERS];
   logic [ORDER_W-1:0]      order_ff [NUM_BUFFERS];
   logic [ORDER_W-1:0]      order_in [NUM_BUFFERS];

   // ring state
   logic                    fill_valid_ff, fill_valid_in;
   logic [BUF_W-1:0]        fill_slot_ff, fill_slot_in;
   logic [CNT_W-1:0]        fill_cnt_ff, fill_cnt_in;
   logic [BUF_W-1:0]        write_slot_ff, write_slot_in;
   logic [ORDER_W-1:0]      next_order_ff, next_order_in;
   logic [FLASH_ADDR_W-1:0] waddr_ff, waddr_in;
   logic                    wip_ff, wip_in;
   logic                    ovf_ff, ovf_in;
   logic [BEAT_W-1:0]       beat_ff, beat_in;
   logic                    taken_ff, taken_in;

   // configuration
   logic [FLASH_ADDR_W-1:0] ring_start_ff, ring_start_in;
   logic [FLASH_ADDR_W-1:0] flash_size_ff, flash_size_in;

   // shared scan unit
   logic [BUF_W-1:0]        scan_idx_ff, scan_idx_in;
   logic                    scan_ready_ff, scan_ready_in;
   logic                    found_ff, found_in;
   logic [BUF_W-1:0]        best_ff, best_in;
   logic [ORDER_W-1:0]      best_order_ff, best_order_in;
   logic [CNT_W-1:0]        best_fill_ff, best_fill_in;

   // page streaming
   logic [BUF_W-1:0]        stream_slot_ff, stream_slot_in;
   logic [WORD_W-1:0]       word_ff, word_in;
   logic [LVL_W-1:0]        level_ff, level_in;
   logic [PAGE_ADDR_W-1:0]  page_addr_ff, page_addr_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [PAGE_ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [DATA_W-1:0]       rsp_word_ff, rsp_word_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;
   logic                    rsp_pend_ff, rsp_pend_in;

   // page store
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr;
   logic                    ram_re;
   logic [ADDR_W-1:0]       ram_raddr;
   logic [DATA_W-1:0]       ram_rdata;

   // misc combinational
   logic                    pending;
   logic                    take;
   logic [CNT_W-1:0]        cnt_next;
   logic                    hit;
   logic                    res_found;
   logic [BUF_W-1:0]        res_idx;
   logic [CNT_W-1:0]        res_fill;

   fpbr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_ch.data_word),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // write address: filling buffer, packet position, beat within packet
   assign ram_waddr = ADDR_W'(fill_slot_ff) * ADDR_W'(WORDS_PER_PAGE)
                    + ADDR_W'(fill_cnt_ff) * ADDR_W'(BEATS_PER_PACKET)
                    + ADDR_W'(beat_ff);
   assign ram_raddr = ADDR_W'(stream_slot_ff) * ADDR_W'(WORDS_PER_PAGE) + ADDR_W'(word_ff);

   // a write in progress or any page ready or writing
   always_comb begin
      pending = wip_ff;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         if (phase_ff[i] == PH_READY || phase_ff[i] == PH_WRITING) begin
            pending = 1'b1;
         end
      end
   end

   // packet acceptance is decided on the first beat
   assign take     = ((beat_ff == '0) ? fill_valid_ff : taken_ff) && fill_valid_ff;
   assign cnt_next = fill_cnt_ff + CNT_W'(1);

   // scan step: empty search takes the first hit, ready search the smallest order
   always_comb begin
      if (scan_ready_ff) begin
         hit = (phase_ff[scan_idx_ff] == PH_READY) &&
               (!found_ff || (order_ff[scan_idx_ff] < best_order_ff));
      end else begin
         hit = (phase_ff[scan_idx_ff] == PH_EMPTY) && !found_ff;
      end
      res_found = found_ff || hit;
      res_idx   = hit ? scan_idx_ff : best_ff;
      res_fill  = hit ? fill_ff[scan_idx_ff] : best_fill_ff;
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      busy_in        = busy_ff;
      full_in        = full_ff;
      status_in      = status_ff;
      phase_in       = phase_ff;
      fill_in        = fill_ff;
      order_in       = order_ff;
      fill_valid_in  = fill_valid_ff;
      fill_slot_in   = fill_slot_ff;
      fill_cnt_in    = fill_cnt_ff;
      write_slot_in  = write_slot_ff;
      next_order_in  = next_order_ff;
      waddr_in       = waddr_ff;
      wip_in         = wip_ff;
      ovf_in         = ovf_ff;
      beat_in        = beat_ff;
      taken_in       = taken_ff;
      ring_start_in  = ring_start_ff;
      flash_size_in  = flash_size_ff;
      scan_idx_in    = scan_idx_ff;
      scan_ready_in  = scan_ready_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      best_order_in  = best_order_ff;
      best_fill_in   = best_fill_ff;
      stream_slot_in = stream_slot_ff;
      word_in        = word_ff;
      level_in       = level_ff;
      page_addr_in   = page_addr_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      rsp_pend_in    = rsp_pend_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            CSR_RING_START: ring_start_in = csr_wdata;
            CSR_FLASH_SIZE: flash_size_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               mode_in     = mode_type'(req_ch.mode);
               busy_in     = req_ch.flash_busy;
               full_in     = ({1'b0, waddr_ff} + SUM_W'(PAGE_BYTES)) > {1'b0, flash_size_ff};
               state_in    = ST_FIN;
               // scan setup, used only where a scan follows
               scan_idx_in = '0;
               found_in    = 1'b0;
               case (mode_type'(req_ch.mode))
                  MODE_BEAT: begin
                     status_in = STAT_REJECTED;
                     taken_in  = take;
                     beat_in   = (beat_ff == BEAT_W'(BEATS_PER_PACKET - 1)) ?
                                 '0 : beat_ff + BEAT_W'(1);
                     if (take) begin
                        ram_we    = 1'b1;
                        status_in = STAT_ACCEPTED;
                        if (beat_ff == BEAT_W'(BEATS_PER_PACKET - 1)) begin
                           fill_cnt_in = cnt_next;
                           if (cnt_next >= CNT_W'(PACKETS_PER_PAGE)) begin
                              // page full: ready with next sequence number
                              phase_in[fill_slot_ff] = PH_READY;
                              order_in[fill_slot_ff] = next_order_ff;
                              fill_in[fill_slot_ff]  = cnt_next;
                              next_order_in          = next_order_ff + ORDER_W'(1);
                              scan_ready_in          = 1'b0;
                              state_in               = ST_SCAN;
                           end
                        end
                     end
                  end
                  MODE_SERVICE: begin
                     if (wip_ff) begin
                        if (req_ch.flash_busy) begin
                           status_in = STAT_BUSY_WAIT;
                        end else begin
                           // write finished, free its buffer
                           status_in               = STAT_DONE;
                           phase_in[write_slot_ff] = PH_EMPTY;
                           fill_in[write_slot_ff]  = '0;
                           order_in[write_slot_ff] = '0;
                           write_slot_in           = '0;
                           wip_in                  = 1'b0;
                           if (!fill_valid_ff) begin
                              scan_ready_in = 1'b0;
                              state_in      = ST_SCAN;
                           end
                        end
                     end else begin
                        scan_ready_in = 1'b1;
                        state_in      = ST_SCAN;
                     end
                  end
                  MODE_FLUSH: begin
                     status_in = STAT_NOTHING;
                     if (fill_valid_ff && fill_cnt_ff != '0) begin
                        phase_in[fill_slot_ff] = PH_READY;
                        order_in[fill_slot_ff] = next_order_ff;
                        fill_in[fill_slot_ff]  = fill_cnt_ff;
                        next_order_in          = next_order_ff + ORDER_W'(1);
                        fill_valid_in          = 1'b0;
                        status_in              = STAT_FLUSHED;
                     end
                     // drop any partial packet
                     beat_in  = '0;
                     taken_in = 1'b0;
                  end
                  MODE_REINIT: begin
                     status_in = STAT_REINIT;
                     for (int i = 0; i < NUM_BUFFERS; i++) begin
                        phase_in[i] = PH_EMPTY;
                        fill_in[i]  = '0;
                        order_in[i] = '0;
                     end
                     phase_in[0]   = PH_FILLING;
                     fill_valid_in = 1'b1;
                     fill_slot_in  = '0;
                     fill_cnt_in   = '0;
                     write_slot_in = '0;
                     next_order_in = '0;
                     waddr_in      = ring_start_ff;
                     wip_in        = 1'b0;
                     ovf_in        = 1'b0;
                     beat_in       = '0;
                     taken_in      = 1'b0;
                  end
                  default: ;
               endcase
            end
         end

         ST_SCAN: begin
            if (hit) begin
               found_in      = 1'b1;
               best_in       = scan_idx_ff;
               best_order_in = order_ff[scan_idx_ff];
               best_fill_in  = fill_ff[scan_idx_ff];
            end
            if (scan_idx_ff != BUF_W'(NUM_BUFFERS - 1)) begin
               scan_idx_in = scan_idx_ff + BUF_W'(1);
            end else begin
               state_in = ST_FIN;
               if (!scan_ready_ff) begin
                  // empty search after page completion or write done
                  if (res_found) begin
                     phase_in[res_idx] = PH_FILLING;
                     fill_in[res_idx]  = '0;
                     order_in[res_idx] = '0;
                     fill_slot_in      = res_idx;
                     fill_cnt_in       = '0;
                     fill_valid_in     = 1'b1;
                     if (mode_ff == MODE_SERVICE) begin
                        ovf_in = 1'b0;
                     end
                  end else if (mode_ff == MODE_BEAT) begin
                     fill_valid_in = 1'b0;
                     ovf_in        = 1'b1;
                     status_in     = STAT_OVERFLOW;
                  end
               end else if (!res_found) begin
                  status_in = STAT_IDLE;
               end else if (full_ff) begin
                  status_in = STAT_FLASH_FULL;
               end else if (busy_ff) begin
                  status_in = STAT_BUSY_SKIP;
               end else begin
                  // start programming the oldest ready page
                  phase_in[res_idx] = PH_WRITING;
                  write_slot_in     = res_idx;
                  wip_in            = 1'b1;
                  page_addr_in      = waddr_ff[PAGE_ADDR_W-1:0];
                  waddr_in          = waddr_ff + FLASH_ADDR_W'(PAGE_BYTES);
                  stream_slot_in    = res_idx;
                  level_in          = LVL_W'(res_fill) * LVL_W'(BEATS_PER_PACKET);
                  word_in           = '0;
                  state_in          = ST_RD;
               end
            end
         end

         ST_FIN: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = 1'b0;
            rsp_status_in = status_ff;
            rsp_addr_in   = '0;
            rsp_word_in   = '0;
            rsp_last_in   = 1'b1;
            rsp_ovf_in    = ovf_ff;
            rsp_pend_in   = pending;
            state_in      = ST_SEND;
         end

         ST_RD: begin
            ram_re   = 1'b1;
            state_in = ST_LOAD;
         end

         ST_LOAD: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = 1'b1;
            rsp_status_in = STAT_STARTED;
            rsp_addr_in   = page_addr_ff;
            // words past the fill level read as erased flash
            rsp_word_in   = ({1'b0, word_ff} < level_ff) ? ram_rdata : '1;
            rsp_last_in   = (word_ff == WORD_W'(WORDS_PER_PAGE - 1));
            rsp_ovf_in    = ovf_ff;
            rsp_pend_in   = pending;
            state_in      = ST_SEND;
         end

         ST_SEND: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_kind_ff && !rsp_last_ff) begin
                  word_in  = word_ff + WORD_W'(1);
                  state_in = ST_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            if (i == 0) begin
               phase_ff[i] <= PH_FILLING;
            end else begin
               phase_ff[i] <= PH_EMPTY;
            end
            fill_ff[i]  <= '0;
            order_ff[i] <= '0;
         end
         fill_valid_ff <= 1'b1;
         fill_slot_ff  <= '0;
         fill_cnt_ff   <= '0;
         write_slot_ff <= '0;
         next_order_ff <= '0;
         waddr_ff      <= RING_START_RESET;
         wip_ff        <= 1'b0;
         ovf_ff        <= 1'b0;
         beat_ff       <= '0;
         taken_ff      <= 1'b0;
         ring_start_ff <= RING_START_RESET;
         flash_size_ff <= FLASH_SIZE_RESET;
         scan_idx_ff   <= '0;
         scan_ready_ff <= 1'b0;
         found_ff      <= 1'b0;
         word_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         fill_ff       <= fill_in;
         order_ff      <= order_in;
         fill_valid_ff <= fill_valid_in;
         fill_slot_ff  <= fill_slot_in;
         fill_cnt_ff   <= fill_cnt_in;
         write_slot_ff <= write_slot_in;
         next_order_ff <= next_order_in;
         waddr_ff      <= waddr_in;
         wip_ff        <= wip_in;
         ovf_ff        <= ovf_in;
         beat_ff       <= beat_in;
         taken_ff      <= taken_in;
         ring_start_ff <= ring_start_in;
         flash_size_ff <= flash_size_in;
         scan_idx_ff   <= scan_idx_in;
         scan_ready_ff <= scan_ready_in;
         found_ff      <= found_in;
         word_ff       <= word_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      // payload, no reset needed
      mode_ff        <= mode_in;
      busy_ff        <= busy_in;
      full_ff        <= full_in;
      status_ff      <= status_in;
      best_ff        <= best_in;
      best_order_ff  <= best_order_in;
      best_fill_ff   <= best_fill_in;
      stream_slot_ff <= stream_slot_in;
      level_ff       <= level_in;
      page_addr_ff   <= page_addr_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_word_ff    <= rsp_word_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_ovf_ff     <= rsp_ovf_in;
      rsp_pend_ff    <= rsp_pend_in;
   end

   // channel outputs
   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.kind         = rsp_kind_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.page_address = rsp_addr_ff;
   assign rsp_ch.page_word    = rsp_word_ff;
   assign rsp_ch.last         = rsp_last_ff;
   assign rsp_ch.overflow     = rsp_ovf_ff;
   assign rsp_ch.pending      = rsp_pend_ff;

   // one transaction in flight: no new request while a result is shown
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("request accepted while a result is outstanding");

   // the buffer being programmed is marked writing
   a_wip_phase: assert property (@(posedge clock) disable iff (reset)
      wip_ff |-> phase_ff[write_slot_ff] == PH_WRITING)
      else $error("write in progress on a buffer not in writing phase");

   // between transactions the fill slot points at a filling buffer
   a_fill_phase: assert property (@(posedge clock) disable iff (reset)
      (fill_valid_ff && state_ff == ST_IDLE) |-> phase_ff[fill_slot_ff] == PH_FILLING)
      else $error("fill slot does not point at a filling buffer");

   // overflow only while no buffer is filling
   a_ovf_no_fill: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> !fill_valid_ff)
      else $error("overflow flagged with a filling buffer available");

   // page data only goes out during a write
   a_beat_wip: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.kind) |-> wip_ff)
      else $error("page beat sent without a write in progress");

endmodule
